/* design/pfdt_pkg.sv */
// Shared package of the page framebuffer dirty tracker.
// Holds the geometry constants, the operation and state codes and the
// command and status bundles between the controller and the datapath.
package pfdt_pkg;

    // Picture geometry and store size.
    localparam int WIDTH       = 128;
    localparam int HEIGHT      = 64;
    localparam int STORE_BYTES = 1024;
    localparam int MAX_BURST   = 64;
    localparam int PAGE_LAST   = (HEIGHT - 1) / 8;

    // Derived widths.
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int POS_W  = 13;
    localparam int CNT_W  = 7;
    localparam int COL_W  = 8;
    localparam int PAGE_W = 5;
    localparam int WLEN_W = 14;

    // Operation codes carried on the input tuser.
    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_CLR    = 3'd1,
        OP_GET    = 3'd2,
        OP_COPY   = 3'd3,
        OP_SHOW   = 3'd4,
        OP_LOCK   = 3'd5,
        OP_UNLOCK = 3'd6,
        OP_CLAIM  = 3'd7
    } pfdt_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PIX,
        ST_WALK,
        ST_READ,
        ST_SEND,
        ST_STATUS
    } pfdt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic pix_rd;
        logic pix_commit;
        logic flag_op;
        logic copy_init;
        logic walk_step;
        logic emit_rd;
        logic load_byte;
        logic load_status;
    } pfdt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        pfdt_op_t op;
        logic     clr_last;
        logic     in_range;
        logic     dirty;
        logic     limit_zero;
        logic     walk_last;
        logic     emit_last;
        logic     out_free;
    } pfdt_sts_t;

endpackage

/* design/pfdt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read.
// Standalone; used for the framebuffer store.
module pfdt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and registered read port; read data holds while re is low.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/pfdt_ctrl.sv */
// Controller state machine of the page framebuffer dirty tracker.
// Depends on pfdt_pkg for the state, operation, command and status types.
module pfdt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pfdt_pkg::pfdt_sts_t sts,
    output pfdt_pkg::pfdt_cmd_t cmd
);

    pfdt_pkg::pfdt_state_t state_reg;
    pfdt_pkg::pfdt_state_t state_next;

    // State register; reset starts the store clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfdt_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pfdt_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = pfdt_pkg::ST_IDLE;
                end
            end
            pfdt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = pfdt_pkg::ST_DECODE;
                end
            end
            pfdt_pkg::ST_DECODE: begin
                unique case (sts.op) inside
                    pfdt_pkg::OP_SET, pfdt_pkg::OP_CLR, pfdt_pkg::OP_GET: begin
                        if (sts.in_range) begin
                            cmd.pix_rd = 1'b1;
                            state_next = pfdt_pkg::ST_PIX;
                        end else begin
                            state_next = pfdt_pkg::ST_STATUS;
                        end
                    end
                    pfdt_pkg::OP_COPY: begin
                        if (!sts.dirty) begin
                            state_next = pfdt_pkg::ST_STATUS;
                        end else begin
                            cmd.copy_init = 1'b1;
                            state_next = sts.limit_zero ? pfdt_pkg::ST_STATUS
                                                        : pfdt_pkg::ST_WALK;
                        end
                    end
                    pfdt_pkg::OP_SHOW, pfdt_pkg::OP_LOCK, pfdt_pkg::OP_UNLOCK,
                    pfdt_pkg::OP_CLAIM: begin
                        cmd.flag_op = 1'b1;
                        state_next  = pfdt_pkg::ST_STATUS;
                    end
                endcase
            end
            pfdt_pkg::ST_PIX: begin
                cmd.pix_commit = 1'b1;
                state_next     = pfdt_pkg::ST_STATUS;
            end
            pfdt_pkg::ST_WALK: begin
                // Dry run of the burst to learn its length and final state.
                cmd.walk_step = 1'b1;
                if (sts.walk_last) begin
                    state_next = pfdt_pkg::ST_READ;
                end
            end
            pfdt_pkg::ST_READ: begin
                cmd.emit_rd = 1'b1;
                state_next  = pfdt_pkg::ST_SEND;
            end
            pfdt_pkg::ST_SEND: begin
                if (sts.out_free) begin
                    cmd.load_byte = 1'b1;
                    state_next = sts.emit_last ? pfdt_pkg::ST_IDLE : pfdt_pkg::ST_READ;
                end
            end
            pfdt_pkg::ST_STATUS: begin
                if (sts.out_free) begin
                    cmd.load_status = 1'b1;
                    state_next      = pfdt_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

/* design/pfdt_dp.sv */
// Datapath of the page framebuffer dirty tracker: item registers, dirty
// rectangle, copy walkers, framebuffer store and output register.
// Depends on pfdt_pkg and instantiates pfdt_ram.
module pfdt_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  pfdt_pkg::pfdt_cmd_t cmd,
    output pfdt_pkg::pfdt_sts_t sts,
    input  logic [23:0]         s_tdata,   // x[7:0], y[15:8], burst_len[22:16]
    input  logic [2:0]          s_tuser,   // op[2:0]
    input  logic                m_tready,
    output logic                m_tvalid,
    // pixel_value[0], data_byte[8:1], is_dirty[9], is_locked[10],
    // dirty_col_first[18:11], dirty_col_last[26:19], dirty_page_first[31:27],
    // dirty_page_last[36:32], window_start_page[41:37], window_length[55:42]
    output logic [55:0]         m_tdata,
    output logic                m_tuser,   // byte_valid[0]
    output logic                m_tlast
);

    localparam int AW = pfdt_pkg::ADDR_W;
    localparam int PW = pfdt_pkg::POS_W;
    localparam int CW = pfdt_pkg::COL_W;
    localparam int GW = pfdt_pkg::PAGE_W;
    localparam int NW = pfdt_pkg::CNT_W;

    typedef struct packed {
        logic [PW:0]   pos;
        logic [CW-1:0] col;
    } walk_t;

    // One step of the row-by-row walk over the dirty window.
    function automatic walk_t walk_step_f(input logic [PW-1:0] pos,
                                          input logic [CW-1:0] col,
                                          input logic [CW-1:0] left,
                                          input logic [CW-1:0] right);
        walk_t r;
        if (col == right) begin
            r.pos = {1'b0, pos} + (PW+1)'(pfdt_pkg::WIDTH) - (PW+1)'(right)
                    + (PW+1)'(left);
            r.col = left;
        end else begin
            r.pos = {1'b0, pos} + 1'b1;
            r.col = (col == CW'(pfdt_pkg::WIDTH - 1)) ? '0 : col + 1'b1;
        end
        return r;
    endfunction

    // Item registers.
    pfdt_pkg::pfdt_op_t op_reg;
    logic [7:0]         x_reg;
    logic [7:0]         y_reg;
    logic [6:0]         blen_reg;

    // Dirty rectangle, flags and kept copy position.
    logic [CW-1:0] left_reg, right_reg;
    logic [GW-1:0] top_reg, bottom_reg;
    logic          dirty_reg, locked_reg, active_reg;
    logic [PW-1:0] cpos_reg;
    logic [CW-1:0] ccol_reg;

    // Clearing sweep, walkers and counters.
    logic [AW-1:0] clr_addr_reg;
    logic [PW-1:0] walk_pos_reg, emit_pos_reg;
    logic [CW-1:0] walk_col_reg, emit_col_reg;
    logic [NW-1:0] walk_cnt_reg, emit_cnt_reg, n_reg;
    logic          pixel_reg, beyond_reg;

    // Output register.
    logic          out_valid_reg;
    logic [55:0]   out_data_reg;
    logic          out_user_reg;
    logic          out_last_reg;

    // Combinational values.
    logic                in_range;
    logic [GW-1:0]       page;
    logic [PW:0]         pix_addr;
    logic                pix_beyond;
    logic [7:0]          bit_mask;
    logic [7:0]          rdata;
    logic [7:0]          rd_byte;
    logic [7:0]          pix_new;
    logic                pix_write_op;
    logic [PW:0]         top_base;
    logic [PW:0]         lastpos;
    logic [PW:0]         start_full;
    logic [PW-1:0]       start_pos;
    logic [CW-1:0]       start_col;
    logic [pfdt_pkg::WLEN_W-1:0] wlen;
    logic [NW-1:0]       limit;
    logic [NW-1:0]       walk_cnt_inc;
    walk_t               walk_nx, emit_nx;
    logic                walk_ended;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata;
    logic                out_free;
    logic                is_claim;

    // Pixel addressing.
    assign in_range   = ({1'b0, x_reg} < 9'(pfdt_pkg::WIDTH))
                     && ({1'b0, y_reg} < 9'(pfdt_pkg::HEIGHT));
    assign page       = y_reg[7:3];
    assign pix_addr   = (PW+1)'(page) * (PW+1)'(pfdt_pkg::WIDTH) + (PW+1)'(x_reg);
    assign pix_beyond = pix_addr >= (PW+1)'(pfdt_pkg::STORE_BYTES);
    assign bit_mask   = 8'(1) << y_reg[2:0];
    assign rd_byte    = beyond_reg ? 8'd0 : rdata;
    assign pix_write_op = (op_reg == pfdt_pkg::OP_SET) || (op_reg == pfdt_pkg::OP_CLR);
    assign pix_new    = (op_reg == pfdt_pkg::OP_SET) ? (rd_byte | bit_mask)
                                                     : (rd_byte & ~bit_mask);

    // Window geometry.
    assign top_base   = (PW+1)'(top_reg) * (PW+1)'(pfdt_pkg::WIDTH);
    assign lastpos    = (PW+1)'(bottom_reg) * (PW+1)'(pfdt_pkg::WIDTH)
                      + (PW+1)'(right_reg);
    assign wlen       = pfdt_pkg::WLEN_W'(lastpos - top_base + 1'b1);
    assign start_full = top_base + (PW+1)'(left_reg);
    assign start_pos  = active_reg ? cpos_reg : start_full[PW-1:0];
    assign start_col  = active_reg ? ccol_reg : left_reg;
    assign limit      = (blen_reg > NW'(pfdt_pkg::MAX_BURST)) ? NW'(pfdt_pkg::MAX_BURST)
                                                              : blen_reg;
    assign is_claim   = op_reg == pfdt_pkg::OP_CLAIM;

    // Walk steps for the dry run and for the emitting pass.
    assign walk_nx      = walk_step_f(walk_pos_reg, walk_col_reg, left_reg, right_reg);
    assign emit_nx      = walk_step_f(emit_pos_reg, emit_col_reg, left_reg, right_reg);
    assign walk_ended   = walk_nx.pos > lastpos;
    assign walk_cnt_inc = walk_cnt_reg + 1'b1;

    // Store ports: the clearing sweep and pixel writes share the write port.
    assign ram_we    = cmd.clr_wr || (cmd.pix_commit && pix_write_op && !pix_beyond);
    assign ram_waddr = cmd.clr_wr ? clr_addr_reg : pix_addr[AW-1:0];
    assign ram_wdata = cmd.clr_wr ? 8'd0 : pix_new;
    assign ram_re    = cmd.pix_rd || cmd.emit_rd;
    assign ram_raddr = cmd.pix_rd ? pix_addr[AW-1:0] : emit_pos_reg[AW-1:0];

    pfdt_ram #(
        .DATA_W (8),
        .DEPTH  (pfdt_pkg::STORE_BYTES)
    ) u_store (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (ram_re),
        .raddr  (ram_raddr),
        .rdata  (rdata)
    );

    // Item capture and pixel read bookkeeping.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= pfdt_pkg::pfdt_op_t'(s_tuser);
            x_reg    <= s_tdata[7:0];
            y_reg    <= s_tdata[15:8];
            blen_reg <= s_tdata[22:16];
        end
        if (cmd.capture) begin
            pixel_reg <= 1'b0;
        end else if (cmd.pix_commit && (op_reg == pfdt_pkg::OP_GET)) begin
            pixel_reg <= rd_byte[y_reg[2:0]];
        end
        if (cmd.pix_rd) begin
            beyond_reg <= pix_beyond;
        end else if (cmd.emit_rd) begin
            beyond_reg <= emit_pos_reg >= PW'(pfdt_pkg::STORE_BYTES);
        end
    end

    // Dirty rectangle, flags and kept copy position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            right_reg  <= CW'(pfdt_pkg::WIDTH - 1);
            top_reg    <= '0;
            bottom_reg <= GW'(pfdt_pkg::PAGE_LAST);
            dirty_reg  <= 1'b1;
            locked_reg <= 1'b0;
            active_reg <= 1'b0;
            cpos_reg   <= '0;
            ccol_reg   <= '0;
        end else if (cmd.pix_commit) begin
            if (pix_write_op) begin
                if (!dirty_reg || (x_reg < left_reg))   left_reg   <= x_reg;
                if (!dirty_reg || (x_reg > right_reg))  right_reg  <= x_reg;
                if (!dirty_reg || (page < top_reg))     top_reg    <= page;
                if (!dirty_reg || (page > bottom_reg))  bottom_reg <= page;
                dirty_reg <= 1'b1;
            end
        end else if (cmd.flag_op) begin
            case (op_reg)
                pfdt_pkg::OP_SHOW:   if (dirty_reg) locked_reg <= 1'b1;
                pfdt_pkg::OP_LOCK:   locked_reg <= 1'b1;
                pfdt_pkg::OP_UNLOCK: locked_reg <= 1'b0;
                pfdt_pkg::OP_CLAIM:  dirty_reg  <= 1'b0;
                default: ;
            endcase
        end else if (cmd.copy_init) begin
            cpos_reg   <= start_pos;
            ccol_reg   <= start_col;
            active_reg <= 1'b1;
        end else if (cmd.walk_step && sts.walk_last) begin
            // Commit the state the burst leaves behind.
            if (walk_ended) begin
                dirty_reg  <= 1'b0;
                locked_reg <= 1'b0;
                active_reg <= 1'b0;
                cpos_reg   <= '0;
                ccol_reg   <= '0;
            end else begin
                cpos_reg <= walk_nx.pos[PW-1:0];
                ccol_reg <= walk_nx.col;
            end
        end
    end

    // Clearing sweep address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Copy walkers and counters.
    always_ff @(posedge aclk) begin
        if (cmd.copy_init) begin
            walk_pos_reg <= start_pos;
            walk_col_reg <= start_col;
            emit_pos_reg <= start_pos;
            emit_col_reg <= start_col;
            walk_cnt_reg <= '0;
            emit_cnt_reg <= '0;
        end else begin
            if (cmd.walk_step) begin
                walk_pos_reg <= walk_nx.pos[PW-1:0];
                walk_col_reg <= walk_nx.col;
                walk_cnt_reg <= walk_cnt_inc;
                if (sts.walk_last) begin
                    n_reg <= walk_cnt_inc;
                end
            end
            if (cmd.emit_rd) begin
                emit_pos_reg <= emit_nx.pos[PW-1:0];
                emit_col_reg <= emit_nx.col;
                emit_cnt_reg <= emit_cnt_reg + 1'b1;
            end
        end
    end

    // Output register; a new item may load as the previous one is taken.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_byte || cmd.load_status) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            out_data_reg <= {pfdt_pkg::WLEN_W'(0), GW'(0), bottom_reg, top_reg,
                             right_reg, left_reg, locked_reg, dirty_reg,
                             rd_byte, 1'b0};
            out_user_reg <= 1'b1;
            out_last_reg <= emit_cnt_reg == n_reg;
        end else if (cmd.load_status) begin
            out_data_reg <= {is_claim ? wlen : pfdt_pkg::WLEN_W'(0),
                             is_claim ? top_reg : GW'(0), bottom_reg, top_reg,
                             right_reg, left_reg, locked_reg, dirty_reg,
                             8'd0, pixel_reg};
            out_user_reg <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller.
    always_comb begin
        sts            = '0;
        sts.op         = op_reg;
        sts.clr_last   = clr_addr_reg == AW'(pfdt_pkg::STORE_BYTES - 1);
        sts.in_range   = in_range;
        sts.dirty      = dirty_reg;
        sts.limit_zero = limit == '0;
        sts.walk_last  = walk_ended || (walk_cnt_inc == limit);
        sts.emit_last  = emit_cnt_reg == n_reg;
        sts.out_free   = out_free;
    end

endmodule

/* design/page_framebuffer_dirty_tracker_core.sv */
// Flag items, out-of-range pixels and empty copies go from decode straight to status;
// in-range pixel items first read the store; set and clear then rewrite one byte.
// A copy walks the window once to size the burst, then reads and sends its bytes one
// at a time, each send waiting while the output is held; the next item is taken after
// the last result is loaded; reset clears the store a byte a cycle, with s_tready low.
// Top level of the page framebuffer dirty tracker; uses pfdt_pkg, pfdt_ctrl, pfdt_dp.
module page_framebuffer_dirty_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // x[7:0], y[15:8], burst_len[22:16]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_value[0], data_byte[8:1], is_dirty[9], is_locked[10],
    // dirty_col_first[18:11], dirty_col_last[26:19], dirty_page_first[31:27],
    // dirty_page_last[36:32], window_start_page[41:37], window_length[55:42]
    output logic [55:0] m_tdata,
    output logic        m_tuser,   // byte_valid[0]
    output logic        m_tlast
);

    pfdt_pkg::pfdt_cmd_t cmd;
    pfdt_pkg::pfdt_sts_t sts;

    // Controller.
    pfdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath with the framebuffer store.
    pfdt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Only one item is in work: an accepted item drops ready in the next cycle.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // A status item, one without a copied byte, always closes its item's results.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("status item not marked last");

    // The dirty rectangle never turns inside out.
    a_rect_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:11] <= m_tdata[26:19])
                  && (m_tdata[31:27] <= m_tdata[36:32]))
        else $error("dirty rectangle bounds out of order");

endmodule
